[hdl/irla_pkg.sv]
`default_nettype none

package irla_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned DIST_W = 8;
  localparam int unsigned PROD_W = 10;

  // calibration curve, reading ascending, distance descending
  localparam int unsigned CURVE_LEN = 20;
  localparam int unsigned CURVE_USED = 20;
  localparam int unsigned POS_W = $clog2(CURVE_LEN);

  localparam logic [SAMPLE_W-1:0] CURVE_READING [CURVE_LEN] = '{
    10'd68,  10'd84,  10'd93,  10'd102, 10'd111, 10'd121, 10'd136, 10'd154, 10'd175, 10'd204,
    10'd243, 10'd300, 10'd309, 10'd331, 10'd353, 10'd371, 10'd408, 10'd433, 10'd462, 10'd502
  };

  localparam logic [DIST_W-1:0] CURVE_CM [CURVE_LEN] = '{
    8'd150, 8'd140, 8'd130, 8'd120, 8'd110, 8'd100, 8'd90, 8'd80, 8'd70, 8'd60,
    8'd50,  8'd40,  8'd38,  8'd36,  8'd33,  8'd30,  8'd28, 8'd25, 8'd23, 8'd20
  };

  typedef struct packed {
    logic                direct;
    logic [DIST_W-1:0]   direct_cm;
    logic [DIST_W-1:0]   base_cm;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] den;
  } curve_t;

endpackage

`default_nettype wire

[hdl/irla_ring.sv]
`default_nettype none

module irla_ring #(
  parameter int unsigned DEPTH  = 10,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/irla_div.sv]
`default_nettype none

module irla_div #(
  parameter int unsigned DIV_W = 14
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q, rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             active_q, done_q;
  logic [DIV_W:0]   shifted, trial;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= CNT_W'(DIV_W);
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      if (!trial[DIV_W]) begin
        rem_q <= trial[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[hdl/irla_curve.sv]
`default_nettype none

module irla_curve
  import irla_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] mean_i,
  output curve_t                   curve_o
);

  localparam int unsigned LAST = CURVE_USED - 1;

  logic [POS_W-1:0]    pos, pos_lo;
  logic                low, high, exact;
  logic [SAMPLE_W-1:0] off;
  logic [DIST_W-1:0]   dcm;
  logic [SAMPLE_W+DIST_W-1:0] full;

  always_comb begin
    pos = POS_W'(LAST);
    for (int i = int'(LAST) - 1; i >= 1; i--) begin
      if (mean_i <= CURVE_READING[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  assign pos_lo = pos - 1'b1;
  assign low    = mean_i <= CURVE_READING[0];
  assign high   = mean_i >= CURVE_READING[LAST];
  assign exact  = mean_i == CURVE_READING[pos];
  assign off    = mean_i - CURVE_READING[pos_lo];
  assign dcm    = CURVE_CM[pos_lo] - CURVE_CM[pos];
  assign full   = {{DIST_W{1'b0}}, off} * {{SAMPLE_W{1'b0}}, dcm};

  always_comb begin
    curve_o.direct  = low | high | exact;
    curve_o.base_cm = CURVE_CM[pos_lo];
    curve_o.prod    = full[PROD_W-1:0];
    curve_o.den     = CURVE_READING[pos] - CURVE_READING[pos_lo];
    if (low) begin
      curve_o.direct_cm = CURVE_CM[0];
    end else if (high) begin
      curve_o.direct_cm = CURVE_CM[LAST];
    end else begin
      curve_o.direct_cm = CURVE_CM[pos];
    end
  end

endmodule

`default_nettype wire

[hdl/ir_range_average_linearizer_top.sv]
// Averages 10-bit range-sensor samples over a ring of the last WINDOW samples
// and maps the truncated mean to a distance in cm through a fixed 20-point
// calibration curve (clamped at 150 cm and 20 cm, linear in between). The
// first sample after reset stands for the whole ring. A running window sum
// is kept next to the sample RAM: each request reads the slot being replaced,
// subtracts it and adds the new sample. The mean is a reciprocal multiply of
// the sum. The interpolation quotient comes from a bit-serial divider, one
// bit per cycle over PROD_W = 10 bits. A request that interpolates passes
// through the read, mean, curve, divide and output states; a mean on a
// breakpoint or a clamp skips the divide. One request is in flight at a
// time, so the next sample is taken only after the output state; a finished
// result waits in the output register while the next sample is taken, and
// the next result holds in the output state, stalling the input, until the
// waiting one is taken.
`default_nettype none

module ir_range_average_linearizer_top
  import irla_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                sample_valid_i,
  output logic                     sample_stall_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  output logic                     result_valid_o,
  input  wire logic                result_stall_i,
  output logic      [DIST_W-1:0]   distance_cm_o,
  output logic      [SAMPLE_W-1:0] mean_reading_o
);

  localparam int unsigned SUM_W  = $clog2(1024 * WINDOW);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam logic [SUM_W-1:0]  WIN_SUM  = SUM_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(WINDOW);

  // floor(sum / WINDOW) = (sum * ceil(2^SH / WINDOW)) >> SH for every sum
  localparam int unsigned RECIP_SH = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W  = SUM_W + 2;
  localparam int unsigned MPROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((1 << RECIP_SH) + WINDOW - 1) / WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MEAN,
    ST_CURVE,
    ST_INTERP,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [CNT_W-1:0]    count_q;
  logic                primed_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] first_q, smp_q, mean_q;
  logic [DIST_W-1:0]   dist_q, base_q;
  logic                out_valid_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic [SAMPLE_W-1:0] out_mean_q;

  logic [SAMPLE_W-1:0] rdata, old;
  logic [MPROD_W-1:0]  mean_prod;
  logic                div_start, div_done;
  logic [PROD_W-1:0]   div_dividend, div_divisor, div_quot;
  curve_t              curve;

  irla_ring #(
    .DEPTH (WINDOW),
    .ADDR_W(SLOT_W),
    .DATA_W(SAMPLE_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_READ),
    .waddr_i(slot_q),
    .wdata_i(smp_q),
    .raddr_i(slot_q),
    .rdata_o(rdata)
  );

  irla_div #(
    .DIV_W(PROD_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  irla_curve u_curve (
    .mean_i (mean_q),
    .curve_o(curve)
  );

  // slots at or beyond the fill count still hold the first sample
  assign old = (CNT_W'(slot_q) < count_q) ? rdata : first_q;

  always_comb begin
    if (!primed_q) begin
      sum_d = SUM_W'(smp_q) * WIN_SUM;
    end else begin
      sum_d = sum_q - SUM_W'(old) + SUM_W'(smp_q);
    end
  end

  assign mean_prod = MPROD_W'(sum_q) * MPROD_W'(RECIP_M);

  assign div_start    = (state_q == ST_CURVE) && !curve.direct;
  assign div_dividend = curve.prod;
  assign div_divisor  = PROD_W'(curve.den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      count_q     <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !result_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (sample_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          primed_q <= 1'b1;
          if (!primed_q) begin
            count_q <= CNT_W'(1);
          end else if (count_q != CNT_FULL) begin
            count_q <= count_q + 1'b1;
          end
          slot_q  <= (slot_q == SLOT_END) ? '0 : slot_q + 1'b1;
          state_q <= ST_MEAN;
        end
        ST_MEAN: begin
          state_q <= ST_CURVE;
        end
        ST_CURVE: begin
          state_q <= curve.direct ? ST_OUT : ST_INTERP;
        end
        ST_INTERP: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !result_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        smp_q <= sample_i;
      end
      ST_READ: begin
        sum_q <= sum_d;
        if (!primed_q) begin
          first_q <= smp_q;
        end
      end
      ST_MEAN: begin
        mean_q <= mean_prod[RECIP_SH +: SAMPLE_W];
      end
      ST_CURVE: begin
        dist_q <= curve.direct_cm;
        base_q <= curve.base_cm;
      end
      ST_INTERP: begin
        if (div_done) begin
          dist_q <= base_q - div_quot[DIST_W-1:0];
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !result_stall_i) begin
          out_dist_q <= dist_q;
          out_mean_q <= mean_q;
        end
      end
      default: begin
        smp_q <= smp_q;
      end
    endcase
  end

  assign sample_stall_o = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign distance_cm_o  = out_dist_q;
  assign mean_reading_o = out_mean_q;

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import irla_pkg::*;

  localparam int unsigned WINDOW_LEN = 10;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_SAMPLES = 1500;

  typedef struct {
    logic [DIST_W-1:0]   distance_cm;
    logic [SAMPLE_W-1:0] mean_reading;
  } range_reading_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                sample_valid = 1'b0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                result_stall = 1'b0;
  logic                sample_stall;
  logic                result_valid;
  logic [DIST_W-1:0]   distance_cm;
  logic [SAMPLE_W-1:0] mean_reading;

  // averaging ring mirror
  logic [SAMPLE_W-1:0] ring [WINDOW_LEN];
  int unsigned         ring_slot = 0;
  bit                  ring_primed = 1'b0;

  range_reading_t      pending_readings [$];
  int unsigned         mismatch_count = 0;
  bit                  idle_on = 1'b1;
  bit                  sink_jitter = 1'b1;
  bit                  long_hold = 1'b0;

  ir_range_average_linearizer_top #(
    .WINDOW(WINDOW_LEN)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_valid_i (sample_valid),
    .sample_stall_o (sample_stall),
    .sample_i       (sample),
    .result_valid_o (result_valid),
    .result_stall_i (result_stall),
    .distance_cm_o  (distance_cm),
    .mean_reading_o (mean_reading)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** ir_range_average_linearizer_top: FAILED **");
    $finish;
  end

  // mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIST_W-1:0] curve_distance(input int v);
    int last;
    int pos;
    int num;
    int den;
    last = int'(CURVE_USED < CURVE_LEN ? CURVE_USED : CURVE_LEN) - 1;
    pos = 1;
    if (last < 1) return CURVE_CM[0];
    if (v <= int'(CURVE_READING[0])) return CURVE_CM[0];
    if (v >= int'(CURVE_READING[last])) return CURVE_CM[last];
    while (pos < last && v > int'(CURVE_READING[pos])) pos++;
    if (v == int'(CURVE_READING[pos])) return CURVE_CM[pos];
    num = (v - int'(CURVE_READING[pos-1])) * (int'(CURVE_CM[pos]) - int'(CURVE_CM[pos-1]));
    den = int'(CURVE_READING[pos]) - int'(CURVE_READING[pos-1]);
    if (den == 0) return CURVE_CM[pos];
    return DIST_W'(num / den + int'(CURVE_CM[pos-1]));
  endfunction

  function automatic range_reading_t average_and_linearize(input logic [SAMPLE_W-1:0] s);
    range_reading_t r;
    int unsigned    sum;
    sum = 0;
    if (!ring_primed) begin
      for (int i = 0; i < WINDOW_LEN; i++) ring[i] = s;
      ring_primed = 1'b1;
    end
    ring[ring_slot] = s;
    ring_slot = (ring_slot + 1 >= WINDOW_LEN) ? 0 : ring_slot + 1;
    for (int i = 0; i < WINDOW_LEN; i++) sum += ring[i];
    r.mean_reading = SAMPLE_W'(sum / WINDOW_LEN);
    r.distance_cm = curve_distance(int'(sum / WINDOW_LEN));
    return r;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_readings.push_back(average_and_linearize(s));
  endtask

  task automatic send_burst(input int target, input int jitter, input int unsigned count);
    int v;
    for (int unsigned i = 0; i < count; i++) begin
      v = target + $urandom_range(0, 2 * jitter) - jitter;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_sample(SAMPLE_W'(v));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // first request fills the ring, so the mean is the sample itself
  task automatic test_first_sample();
    send_sample(10'd300);
  endtask

  task automatic test_extremes();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_burst(68, 0, WINDOW_LEN);
    send_burst(502, 0, WINDOW_LEN);
    send_sample(10'd1023);
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    send_burst(200, 40, 16);
    drain_results();
  endtask

  task automatic test_random_readings(input int unsigned total);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < total) begin
      if (sent % 100 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        sink_jitter = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 3) != 0) begin
        n = WINDOW_LEN;
        send_burst($urandom_range(40, 560), $urandom_range(0, 4), n);
      end else begin
        n = $urandom_range(1, WINDOW_LEN);
        for (int unsigned i = 0; i < n; i++) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
      end
      sent += n;
    end
  endtask

  initial begin : result_sink
    int unsigned n;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        result_stall <= 1'b0;
      end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
        n = pick_gap() + 1;
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    range_reading_t want;
    if (rst_n && result_valid === 1'b1 && !result_stall) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: distance_cm %0d mean_reading %0d", distance_cm, mean_reading);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        if (distance_cm !== want.distance_cm) begin
          $error("distance_cm: expected %0d, got %0d", want.distance_cm, distance_cm);
          mismatch_count++;
        end
        if (mean_reading !== want.mean_reading) begin
          $error("mean_reading: expected %0d, got %0d", want.mean_reading, mean_reading);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    test_first_sample();
    test_extremes();
    test_backpressure();
    test_random_readings(RANDOM_SAMPLES);
    @(negedge clk);
    sample_valid <= 1'b0;
    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("** ir_range_average_linearizer_top: PASSED **");
    end else begin
      $display("** ir_range_average_linearizer_top: FAILED **");
    end
    $finish;
  end

endmodule
